[rtl/ccr_pkg.sv]
// Shared types and constants of the circle collision resolver.
// Used by ccr_impulse and circle_collision_resolve_top; depends on nothing.
`timescale 1ns / 1ps

package ccr_pkg;

  // fixed-point formats
  localparam int FRAC_BITS = 16;
  localparam int W_BITS    = 28;
  localparam int CFG_W     = 17;
  localparam int CFG_ADDR_W = 1;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_RESTITUTION = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CORRECTION  = 1'd1;

  localparam logic [CFG_W-1:0] RESTITUTION_RESET = 17'd62259;
  localparam logic [CFG_W-1:0] CORRECTION_RESET  = 17'd13107;
  localparam logic [17:0]      ONE_Q16           = 18'd65536;

  // front pipeline layout: input, squares, sum, root steps, divide setup, divide steps
  localparam int SQ_FIRST   = 3;
  localparam int SQ_STEPS   = 33;
  localparam int DIV_INIT   = SQ_FIRST + SQ_STEPS;
  localparam int DIV_FIRST  = DIV_INIT + 1;
  localparam int DIV_STEPS  = 17;
  localparam int NUM_FRONT  = DIV_FIRST + DIV_STEPS;
  localparam int NUM_IMP    = 8;

  typedef struct packed {
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic signed [31:0] a_vel_x;
    logic signed [31:0] a_vel_y;
    logic        [31:0] a_mass;
    logic        [30:0] a_radius;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic signed [31:0] b_vel_x;
    logic signed [31:0] b_vel_y;
    logic        [31:0] b_mass;
    logic        [30:0] b_radius;
  } in_t;

  typedef struct packed {
    logic signed [31:0] new_a_pos_x;
    logic signed [31:0] new_a_pos_y;
    logic signed [31:0] new_a_vel_x;
    logic signed [31:0] new_a_vel_y;
    logic signed [31:0] new_b_pos_x;
    logic signed [31:0] new_b_pos_y;
    logic signed [31:0] new_b_vel_x;
    logic signed [31:0] new_b_vel_y;
    logic               resolved;
  } out_t;

  // context through the distance, mass weight and normal pipeline
  typedef struct packed {
    in_t         item;
    logic        sgx;
    logic        sgy;
    logic [32:0] sx;
    logic [32:0] sy;
    logic [31:0] rsum;
    logic [32:0] msum;
    logic [64:0] qx;
    logic [64:0] qy;
    logic [65:0] dsq;
    logic [35:0] sq_rem;
    logic [32:0] sq_root;
    logic [60:0] w_rem;
    logic [27:0] wa;
    logic [49:0] nx_rem;
    logic [49:0] ny_rem;
    logic [16:0] qnx;
    logic [16:0] qny;
  } ctx_t;

  // context through the impulse pipeline
  typedef struct packed {
    in_t                item;
    logic               ovl;
    logic               hit;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [32:0] rvx;
    logic signed [32:0] rvy;
    logic        [27:0] wa;
    logic        [27:0] wb;
    logic        [31:0] pd;
    logic signed [50:0] px;
    logic signed [50:0] py;
    logic        [48:0] pcp;
    logic signed [35:0] van;
    logic        [32:0] pc;
    logic signed [54:0] sp;
    logic        [60:0] cap;
    logic        [60:0] cbp;
    logic signed [38:0] s;
    logic        [32:0] ca;
    logic        [32:0] cb;
    logic signed [67:0] sap;
    logic signed [67:0] sbp;
    logic signed [57:0] t_avx;
    logic signed [57:0] t_avy;
    logic signed [57:0] t_bvx;
    logic signed [57:0] t_bvy;
    logic signed [57:0] t_apx;
    logic signed [57:0] t_apy;
    logic signed [57:0] t_bpx;
    logic signed [57:0] t_bpy;
    out_t               res;
  } imp_t;

  // clamp to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [43:0] v);
    logic signed [43:0] hi;
    logic signed [43:0] lo;
    hi = 44'sd2147483647;
    lo = -44'sd2147483648;
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return $signed(v[31:0]);
  endfunction

endpackage

[rtl/circle_collision_resolve_top.sv]
// Top level of the circle collision resolver: distance, weight and normal pipeline.
// Instantiates ccr_impulse; uses ccr_pkg.
`timescale 1ns / 1ps

// Resolves one pair of circles per clock cycle in a fully pipelined datapath, as long
// as the output is not stalled. A pair passes through 54 front stages
// (squared distance, a 33-step square root with the mass-weight divider running
// alongside, then a 17-step normal divider) and 8 impulse stages, the last of
// which is the output register. The whole pipe advances whenever the output
// register is empty or being taken, so in_ready follows out_ready combinationally.
// Configuration writes take effect on pairs that reach the impulse stages after
// the write; write only while the pipe is empty.

module circle_collision_resolve_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  ccr_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output ccr_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [ccr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ccr_pkg::CFG_W-1:0]       cfg_data
);
  import ccr_pkg::*;

  logic                 en;
  logic [CFG_W-1:0]     restitution;
  logic [CFG_W-1:0]     correction_fraction;
  ctx_t                 ctx [NUM_FRONT];
  logic [NUM_FRONT-1:0] vld;

  // pipe advance
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      restitution         <= RESTITUTION_RESET;
      correction_fraction <= CORRECTION_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_RESTITUTION: restitution         <= cfg_data;
        REG_CORRECTION:  correction_fraction <= cfg_data;
        default: ;
      endcase
    end
  end

  // valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_FRONT-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < NUM_FRONT; g++) begin : g_st
    ctx_t nxt;

    if (g == 0) begin : g_in
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic        [31:0] m1;
      logic        [31:0] m2;
      // center offset, radius sum, mass sum
      always_comb begin
        dx = 33'(in_data.b_pos_x) - 33'(in_data.a_pos_x);
        dy = 33'(in_data.b_pos_y) - 33'(in_data.a_pos_y);
        m1 = (in_data.a_mass == '0) ? 32'd1 : in_data.a_mass;
        m2 = (in_data.b_mass == '0) ? 32'd1 : in_data.b_mass;
        nxt = '0;
        nxt.item = in_data;
        nxt.sgx = dx[32];
        nxt.sgy = dy[32];
        nxt.sx = dx[32] ? 33'(-dx) : 33'(dx);
        nxt.sy = dy[32] ? 33'(-dy) : 33'(dy);
        nxt.rsum = 32'(in_data.a_radius) + 32'(in_data.b_radius);
        nxt.msum = 33'(m1) + 33'(m2);
        nxt.w_rem = 61'(m2) << W_BITS;
      end
    end else if (g == 1) begin : g_sq
      always_comb begin
        nxt = ctx[g-1];
        nxt.qx = 65'(ctx[g-1].sx * ctx[g-1].sx);
        nxt.qy = 65'(ctx[g-1].sy * ctx[g-1].sy);
      end
    end else if (g == 2) begin : g_sum
      always_comb begin
        nxt = ctx[g-1];
        nxt.dsq = 66'(ctx[g-1].qx) + 66'(ctx[g-1].qy);
        nxt.sq_rem = '0;
        nxt.sq_root = '0;
      end
    end else if (g < DIV_INIT) begin : g_root
      localparam int J = g - SQ_FIRST;
      localparam int P = SQ_STEPS - 1 - J;
      logic [35:0] rem2;
      logic [35:0] trial;
      logic        ge;
      // root stages also carry the weight divider fields
      logic [60:0] nxt_w_rem;
      logic [27:0] nxt_wa;
      // one root bit per stage, restoring method
      always_comb begin
        rem2 = {ctx[g-1].sq_rem[33:0], ctx[g-1].dsq[2*P+1 -: 2]};
        trial = 36'({ctx[g-1].sq_root, 2'b01});
        ge = rem2 >= trial;
        nxt = ctx[g-1];
        nxt.sq_rem = ge ? (rem2 - trial) : rem2;
        nxt.sq_root = {ctx[g-1].sq_root[31:0], ge};
      end
      if (J < W_BITS) begin : g_wdiv
        localparam int K = W_BITS - 1 - J;
        logic [60:0] dv;
        logic        wge;
        // one bit of the mass weight per stage
        always_comb begin
          dv = 61'(ctx[g-1].msum) << K;
          wge = ctx[g-1].w_rem >= dv;
          nxt_w_rem = wge ? (ctx[g-1].w_rem - dv) : ctx[g-1].w_rem;
          nxt_wa = ctx[g-1].wa | (28'(wge) << K);
        end
      end else begin : g_wpass
        always_comb begin
          nxt_w_rem = ctx[g-1].w_rem;
          nxt_wa = ctx[g-1].wa;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          ctx[g] <= '{item: nxt.item, sgx: nxt.sgx, sgy: nxt.sgy, sx: nxt.sx, sy: nxt.sy,
                      rsum: nxt.rsum, msum: nxt.msum, qx: nxt.qx, qy: nxt.qy,
                      dsq: nxt.dsq, sq_rem: nxt.sq_rem, sq_root: nxt.sq_root,
                      w_rem: nxt_w_rem, wa: nxt_wa, nx_rem: nxt.nx_rem,
                      ny_rem: nxt.ny_rem, qnx: nxt.qnx, qny: nxt.qny};
        end
      end
    end else if (g == DIV_INIT) begin : g_dinit
      always_comb begin
        nxt = ctx[g-1];
        nxt.nx_rem = 50'(ctx[g-1].sx) << FRAC_BITS;
        nxt.ny_rem = 50'(ctx[g-1].sy) << FRAC_BITS;
        nxt.qnx = '0;
        nxt.qny = '0;
      end
    end else begin : g_ndiv
      localparam int K = DIV_STEPS - 1 - (g - DIV_FIRST);
      logic [49:0] dv;
      logic        gx;
      logic        gy;
      // one bit of each normal component per stage
      always_comb begin
        dv = 50'(ctx[g-1].sq_root) << K;
        gx = ctx[g-1].nx_rem >= dv;
        gy = ctx[g-1].ny_rem >= dv;
        nxt = ctx[g-1];
        nxt.nx_rem = gx ? (ctx[g-1].nx_rem - dv) : ctx[g-1].nx_rem;
        nxt.ny_rem = gy ? (ctx[g-1].ny_rem - dv) : ctx[g-1].ny_rem;
        nxt.qnx = ctx[g-1].qnx | (17'(gx) << K);
        nxt.qny = ctx[g-1].qny | (17'(gy) << K);
      end
    end

    if ((g < SQ_FIRST) || (g >= DIV_INIT)) begin : g_plain
      always_ff @(posedge clk) begin
        if (en) begin
          ctx[g] <= nxt;
        end
      end
    end
  end

  ccr_impulse u_impulse (
    .clk                 (clk),
    .rst                 (rst),
    .en                  (en),
    .ctx_valid           (vld[NUM_FRONT-1]),
    .ctx_in              (ctx[NUM_FRONT-1]),
    .restitution         (restitution),
    .correction_fraction (correction_fraction),
    .res_valid           (out_valid),
    .res_data            (out_data)
  );

endmodule

[rtl/ccr_impulse.sv]
// Impulse and position correction pipeline of the circle collision resolver.
// Takes the normal, distance and mass weights from the front pipeline; uses ccr_pkg.
`timescale 1ns / 1ps

module ccr_impulse (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        ctx_valid,
  input  ccr_pkg::ctx_t               ctx_in,
  input  logic [ccr_pkg::CFG_W-1:0]   restitution,
  input  logic [ccr_pkg::CFG_W-1:0]   correction_fraction,
  output logic                        res_valid,
  output ccr_pkg::out_t               res_data
);
  import ccr_pkg::*;

  imp_t               imp [NUM_IMP];
  logic [NUM_IMP-1:0] vld;

  // valid bits travel with the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NUM_IMP-2:0], ctx_valid};
    end
  end

  for (genvar g = 0; g < NUM_IMP; g++) begin : g_st
    imp_t nxt;

    if (g == 0) begin : g_setup
      logic [32:0] root_dist;
      // normal sign, overlap test, relative velocity, weights and depth
      always_comb begin
        root_dist = ctx_in.sq_root;
        nxt = '0;
        nxt.item = ctx_in.item;
        nxt.ovl = (ctx_in.dsq != '0) && (33'(ctx_in.rsum) > root_dist);
        nxt.nx = ctx_in.sgx ? -$signed({1'b0, ctx_in.qnx}) : $signed({1'b0, ctx_in.qnx});
        nxt.ny = ctx_in.sgy ? -$signed({1'b0, ctx_in.qny}) : $signed({1'b0, ctx_in.qny});
        nxt.rvx = 33'(ctx_in.item.b_vel_x) - 33'(ctx_in.item.a_vel_x);
        nxt.rvy = 33'(ctx_in.item.b_vel_y) - 33'(ctx_in.item.a_vel_y);
        nxt.wa = ctx_in.wa;
        nxt.wb = 28'((29'(1) << W_BITS) - 29'(ctx_in.wa) - 29'(|ctx_in.w_rem));
        nxt.pd = ctx_in.rsum - root_dist[31:0];
      end
    end else if (g == 1) begin : g_dot
      // per-axis products of the normal speed and the depth scaling
      always_comb begin
        nxt = imp[g-1];
        nxt.px = 51'(imp[g-1].rvx * imp[g-1].nx);
        nxt.py = 51'(imp[g-1].rvy * imp[g-1].ny);
        nxt.pcp = 49'(imp[g-1].pd * correction_fraction);
      end
    end else if (g == 2) begin : g_van
      always_comb begin
        nxt = imp[g-1];
        nxt.van = 36'((52'(imp[g-1].px) + 52'(imp[g-1].py)) >>> FRAC_BITS);
        nxt.pc = imp[g-1].pcp[48:16];
      end
    end else if (g == 3) begin : g_scale
      logic [17:0] fac;
      // restitution scaling, correction weights, collision decision
      always_comb begin
        fac = ONE_Q16 + 18'(restitution);
        nxt = imp[g-1];
        nxt.sp = 55'(imp[g-1].van * $signed({1'b0, fac}));
        nxt.cap = 61'(imp[g-1].pc * imp[g-1].wa);
        nxt.cbp = 61'(imp[g-1].pc * imp[g-1].wb);
        nxt.hit = imp[g-1].ovl && (imp[g-1].van[35] || (imp[g-1].van == '0));
      end
    end else if (g == 4) begin : g_shift
      always_comb begin
        nxt = imp[g-1];
        nxt.s = 39'(imp[g-1].sp >>> 16);
        nxt.ca = imp[g-1].cap[60:28];
        nxt.cb = imp[g-1].cbp[60:28];
      end
    end else if (g == 5) begin : g_split
      // share of the impulse for each circle
      always_comb begin
        nxt = imp[g-1];
        nxt.sap = 68'(imp[g-1].s * $signed({1'b0, imp[g-1].wa}));
        nxt.sbp = 68'(imp[g-1].s * $signed({1'b0, imp[g-1].wb}));
      end
    end else if (g == 6) begin : g_proj
      logic signed [39:0] sa;
      logic signed [39:0] sb;
      // project the shares back on the normal
      always_comb begin
        sa = 40'(imp[g-1].sap >>> W_BITS);
        sb = 40'(imp[g-1].sbp >>> W_BITS);
        nxt = imp[g-1];
        nxt.t_avx = 58'(sa * imp[g-1].nx);
        nxt.t_avy = 58'(sa * imp[g-1].ny);
        nxt.t_bvx = 58'(sb * imp[g-1].nx);
        nxt.t_bvy = 58'(sb * imp[g-1].ny);
        nxt.t_apx = 58'($signed({1'b0, imp[g-1].ca}) * imp[g-1].nx);
        nxt.t_apy = 58'($signed({1'b0, imp[g-1].ca}) * imp[g-1].ny);
        nxt.t_bpx = 58'($signed({1'b0, imp[g-1].cb}) * imp[g-1].nx);
        nxt.t_bpy = 58'($signed({1'b0, imp[g-1].cb}) * imp[g-1].ny);
      end
    end else begin : g_apply
      imp_t p;
      // apply the deltas with saturation, or pass the pair through
      always_comb begin
        p = imp[g-1];
        nxt = p;
        nxt.res.resolved = p.hit;
        nxt.res.new_a_pos_x = p.item.a_pos_x;
        nxt.res.new_a_pos_y = p.item.a_pos_y;
        nxt.res.new_a_vel_x = p.item.a_vel_x;
        nxt.res.new_a_vel_y = p.item.a_vel_y;
        nxt.res.new_b_pos_x = p.item.b_pos_x;
        nxt.res.new_b_pos_y = p.item.b_pos_y;
        nxt.res.new_b_vel_x = p.item.b_vel_x;
        nxt.res.new_b_vel_y = p.item.b_vel_y;
        if (p.hit) begin
          nxt.res.new_a_vel_x = sat32(44'(p.item.a_vel_x) + 44'(p.t_avx >>> FRAC_BITS));
          nxt.res.new_a_vel_y = sat32(44'(p.item.a_vel_y) + 44'(p.t_avy >>> FRAC_BITS));
          nxt.res.new_b_vel_x = sat32(44'(p.item.b_vel_x) - 44'(p.t_bvx >>> FRAC_BITS));
          nxt.res.new_b_vel_y = sat32(44'(p.item.b_vel_y) - 44'(p.t_bvy >>> FRAC_BITS));
          nxt.res.new_a_pos_x = sat32(44'(p.item.a_pos_x) - 44'(p.t_apx >>> FRAC_BITS));
          nxt.res.new_a_pos_y = sat32(44'(p.item.a_pos_y) - 44'(p.t_apy >>> FRAC_BITS));
          nxt.res.new_b_pos_x = sat32(44'(p.item.b_pos_x) + 44'(p.t_bpx >>> FRAC_BITS));
          nxt.res.new_b_pos_y = sat32(44'(p.item.b_pos_y) + 44'(p.t_bpy >>> FRAC_BITS));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        imp[g] <= nxt;
      end
    end
  end

  assign res_valid = vld[NUM_IMP-1];
  assign res_data  = imp[NUM_IMP-1].res;

endmodule

[bench/circle_collision_resolve_top_test.sv]
// Self-checking bench for circle_collision_resolve_top: directed and random pairs
// against a bit-exact impulse predictor. Depends on ccr_pkg and the top level.
`timescale 1ns / 1ps

module circle_collision_resolve_top_test;
  import ccr_pkg::*;

  typedef logic signed [127:0] wide_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_RESTITUTION;
  logic [CFG_W-1:0] cfg_data = '0;

  // predictor copy of the registers
  logic [CFG_W-1:0] restit_q = RESTITUTION_RESET;
  logic [CFG_W-1:0] corr_q = CORRECTION_RESET;

  out_t pending_results[$];
  int errors = 0;
  bit idle_on = 1'b1;
  int hold_cycles = 0;

  circle_collision_resolve_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // floor of the square root of a 66-bit value
  function automatic wide_t int_sqrt(logic [65:0] v);
    logic [67:0] rem;
    logic [67:0] root;
    logic [67:0] trial;
    rem = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      rem = (rem << 2) | v[2*i +: 2];
      trial = (root << 2) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 1;
      end else begin
        root = root << 1;
      end
    end
    return wide_t'(root);
  endfunction

  function automatic logic signed [31:0] clamp32(wide_t v);
    if (v > 128'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // impulse and positional correction of one pair
  function automatic out_t resolve_pair(in_t p);
    wide_t apx, apy, avx, avy, bpx, bpy, bvx, bvy;
    wide_t ma, mb, ra, rb, dx, dy, cdist, rsum, nx, ny, van;
    wide_t wa, wb, s, sa, sb, pc, ca, cb;
    out_t r;
    apx = p.a_pos_x; apy = p.a_pos_y; avx = p.a_vel_x; avy = p.a_vel_y;
    bpx = p.b_pos_x; bpy = p.b_pos_y; bvx = p.b_vel_x; bvy = p.b_vel_y;
    ma = (p.a_mass == 0) ? 1 : p.a_mass;
    mb = (p.b_mass == 0) ? 1 : p.b_mass;
    ra = p.a_radius;
    rb = p.b_radius;
    r.new_a_pos_x = p.a_pos_x; r.new_a_pos_y = p.a_pos_y;
    r.new_a_vel_x = p.a_vel_x; r.new_a_vel_y = p.a_vel_y;
    r.new_b_pos_x = p.b_pos_x; r.new_b_pos_y = p.b_pos_y;
    r.new_b_vel_x = p.b_vel_x; r.new_b_vel_y = p.b_vel_y;
    r.resolved = 1'b0;
    dx = bpx - apx;
    dy = bpy - apy;
    cdist = int_sqrt(66'(dx * dx + dy * dy));
    rsum = ra + rb;
    // coincident centres and non-overlapping pairs pass through
    if ((dx == 0 && dy == 0) || rsum <= cdist) return r;
    nx = (dx <<< FRAC_BITS) / cdist;
    ny = (dy <<< FRAC_BITS) / cdist;
    van = ((bvx - avx) * nx + (bvy - avy) * ny) >>> FRAC_BITS;
    // separating pairs pass through
    if (van > 0) return r;
    wa = (mb <<< W_BITS) / (ma + mb);
    wb = (ma <<< W_BITS) / (ma + mb);
    s = (van * (wide_t'(65536) + wide_t'(restit_q))) >>> 16;
    sa = (s * wa) >>> W_BITS;
    sb = (s * wb) >>> W_BITS;
    pc = ((rsum - cdist) * wide_t'(corr_q)) >>> 16;
    ca = (pc * wa) >>> W_BITS;
    cb = (pc * wb) >>> W_BITS;
    r.new_a_vel_x = clamp32(avx + ((sa * nx) >>> FRAC_BITS));
    r.new_a_vel_y = clamp32(avy + ((sa * ny) >>> FRAC_BITS));
    r.new_b_vel_x = clamp32(bvx - ((sb * nx) >>> FRAC_BITS));
    r.new_b_vel_y = clamp32(bvy - ((sb * ny) >>> FRAC_BITS));
    r.new_a_pos_x = clamp32(apx - ((ca * nx) >>> FRAC_BITS));
    r.new_a_pos_y = clamp32(apy - ((ca * ny) >>> FRAC_BITS));
    r.new_b_pos_x = clamp32(bpx + ((cb * nx) >>> FRAC_BITS));
    r.new_b_pos_y = clamp32(bpy + ((cb * ny) >>> FRAC_BITS));
    r.resolved = 1'b1;
    return r;
  endfunction

  // random value with a random magnitude
  function automatic logic [31:0] rand_mag();
    int unsigned sh;
    sh = $urandom_range(0, 31);
    return $urandom >> sh;
  endfunction

  function automatic logic signed [31:0] rand_signed();
    logic [31:0] v;
    v = rand_mag();
    return ($urandom_range(0, 1) != 0) ? -v : v;
  endfunction

  // mostly close, approaching pairs; some fully random noise
  function automatic in_t rand_pair();
    in_t p;
    logic [31:0] reach;
    p.a_pos_x = $urandom; p.a_pos_y = $urandom;
    p.a_vel_x = rand_signed(); p.a_vel_y = rand_signed();
    p.b_vel_x = rand_signed(); p.b_vel_y = rand_signed();
    p.a_mass = rand_mag(); p.b_mass = rand_mag();
    if ($urandom_range(0, 9) < 2) begin
      p.b_pos_x = $urandom; p.b_pos_y = $urandom;
      p.a_radius = $urandom; p.b_radius = $urandom;
      p.a_mass = $urandom; p.b_mass = $urandom;
    end else begin
      reach = rand_mag();
      p.b_pos_x = p.a_pos_x + ($signed(reach) >>> $urandom_range(0, 2)) *
                  ($urandom_range(0, 1) ? 1 : -1);
      p.b_pos_y = p.a_pos_y + ($signed(reach) >>> $urandom_range(0, 3)) *
                  ($urandom_range(0, 1) ? 1 : -1);
      p.a_radius = 31'(reach >> 1) + 31'($urandom_range(0, 65536));
      p.b_radius = 31'(reach >> 1) + 31'($urandom_range(0, 65536));
      // push the pair toward each other along the separation
      if ($urandom_range(0, 3) != 0) begin
        p.a_vel_x = $signed(p.b_pos_x - p.a_pos_x) >>> $urandom_range(0, 8);
        p.a_vel_y = $signed(p.b_pos_y - p.a_pos_y) >>> $urandom_range(0, 8);
      end
    end
    return p;
  endfunction

  task automatic send_pair(in_t p);
    int unsigned gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= p;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_results = {pending_results, resolve_pair(p)};
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RESTITUTION) restit_q = val;
    else corr_q = val;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  function automatic in_t make_pair(logic signed [31:0] ax, ay, avx, avy,
                                    logic [31:0] am, logic [30:0] ar,
                                    logic signed [31:0] bx, by, bvx, bvy,
                                    logic [31:0] bm, logic [30:0] br);
    in_t p;
    p = '{ax, ay, avx, avy, am, ar, bx, by, bvx, bvy, bm, br};
    return p;
  endfunction

  task automatic test_directed();
    // head-on approach, equal masses
    send_pair(make_pair(0, 0, 32'sh10000, 0, 32'h10000, 31'h10000,
                        32'sh18000, 0, -32'sh10000, 0, 32'h10000, 31'h10000));
    // coincident centres
    send_pair(make_pair(5, 7, 1, 2, 3, 31'h7FFFFFFF, 5, 7, -1, -2, 4, 31'h7FFFFFFF));
    // separating pair
    send_pair(make_pair(0, 0, -32'sh10000, 0, 32'h10000, 31'h10000,
                        32'sh10000, 0, 32'sh10000, 0, 32'h10000, 31'h10000));
    // zero normal velocity still resolves
    send_pair(make_pair(0, 0, 0, 32'sh50000, 32'h20000, 31'h10000,
                        32'sh10000, 0, 0, 32'sh50000, 32'h10000, 31'h10000));
    // no overlap, exactly touching
    send_pair(make_pair(0, 0, 32'sh10000, 0, 1, 31'h8000,
                        32'sh10000, 0, 0, 0, 1, 31'h8000));
    // zero masses
    send_pair(make_pair(0, 0, 32'sh30000, 32'sh1000, 0, 31'h20000,
                        32'sh8000, 32'sh8000, 0, 0, 0, 31'h20000));
    // one mass tiny, the other huge
    send_pair(make_pair(0, 0, 32'sh7FFFFFFF, 0, 1, 31'h40000,
                        32'sh10000, 32'sh100, 32'sh80000000, 0, 32'hFFFFFFFF, 31'h40000));
    // opposite extremes of the position range with maximum radii
    send_pair(make_pair(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF,
                        32'hFFFFFFFF, 31'h7FFFFFFF,
                        32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000,
                        32'hFFFFFFFF, 31'h7FFFFFFF));
    send_pair(make_pair(32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                        32'h1, 31'h7FFFFFFF,
                        32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                        32'h1, 31'h7FFFFFFF));
    // saturating positions near the edge
    send_pair(make_pair(32'sh7FFF0000, 0, 0, 0, 32'h10000, 31'h7FFFFFFF,
                        32'sh7FFFFFFF, 1, 32'sh80000000, 0, 32'h100, 31'h7FFFFFFF));
    send_pair(make_pair(32'sh80000000, 0, 32'sh7FFFFFFF, 0, 32'h100, 31'h7FFFFFFF,
                        32'sh80010000, 0, 0, 0, 32'h10000, 31'h7FFFFFFF));
    // all zero, all ones
    send_pair('0);
    send_pair('1);
    // overlap at a distance of one LSB, then a diagonal overlap
    send_pair(make_pair(100, 100, 3, 3, 2, 1, 101, 100, -3, 0, 5, 1));
    send_pair(make_pair(0, 0, 32'sh20000, -32'sh20000, 32'h8000, 31'h30000,
                        32'sh10000, -32'sh10000, 0, 0, 32'h18000, 31'h10000));
    drain();
  endtask

  task automatic test_random(int n);
    idle_on = 1'b1;
    for (int i = 0; i < n; i++) begin
      // stretches with no idling on either side
      if (i % 60 == 0) idle_on = ($urandom_range(0, 2) != 0);
      send_pair(rand_pair());
    end
    idle_on = 1'b1;
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 150;
    idle_on = 1'b0;
    for (int i = 0; i < 100; i++) send_pair(rand_pair());
    idle_on = 1'b1;
    drain();
  endtask

  task automatic test_config_sweep();
    write_reg(REG_RESTITUTION, '0);
    write_reg(REG_CORRECTION, '0);
    test_random(185);
    write_reg(REG_RESTITUTION, 17'd65536);
    write_reg(REG_CORRECTION, 17'd65536);
    test_random(185);
    write_reg(REG_RESTITUTION, 17'h1FFFF);
    write_reg(REG_CORRECTION, 17'h1FFFF);
    test_random(185);
    write_reg(REG_RESTITUTION, CFG_W'($urandom_range(0, 131071)));
    write_reg(REG_CORRECTION, CFG_W'($urandom_range(0, 131071)));
    test_random(185);
  endtask

  // receiver: random stall per beat, one long hold-off on request
  initial begin
    int unsigned wait_n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        wait_n = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_n = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t %s mismatch: expected %h, actual %h", $realtime, name, exp_v, act_v);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none, actual %h", $realtime, out_data);
      end else begin
        want = pending_results.pop_front();
        compare_field("new_a_pos_x", want.new_a_pos_x, out_data.new_a_pos_x);
        compare_field("new_a_pos_y", want.new_a_pos_y, out_data.new_a_pos_y);
        compare_field("new_a_vel_x", want.new_a_vel_x, out_data.new_a_vel_x);
        compare_field("new_a_vel_y", want.new_a_vel_y, out_data.new_a_vel_y);
        compare_field("new_b_pos_x", want.new_b_pos_x, out_data.new_b_pos_x);
        compare_field("new_b_pos_y", want.new_b_pos_y, out_data.new_b_pos_y);
        compare_field("new_b_vel_x", want.new_b_vel_x, out_data.new_b_vel_x);
        compare_field("new_b_vel_y", want.new_b_vel_y, out_data.new_b_vel_y);
        compare_field("resolved", 32'(want.resolved), 32'(out_data.resolved));
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_config_sweep();
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t results missing: expected %0d more, actual 0", $realtime,
               pending_results.size());
    end
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin
    #20000000;
    $display("status: fail");
    $finish;
  end

endmodule
